@@ rtl/core/base64_stream_decoder_macros.svh @@
// Assertion helpers used by the decoder queue RTL.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Same-cycle implication.
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/b64d_pkg.sv @@
package b64d_pkg;

	localparam logic [7:0] CHAR_UPPER_A = 8'd65;
	localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
	localparam logic [7:0] CHAR_LOWER_A = 8'd97;
	localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
	localparam logic [7:0] CHAR_PLUS    = 8'd43;
	localparam logic [7:0] CHAR_SLASH   = 8'd47;
	localparam logic [7:0] CHAR_PAD     = 8'd61;

	localparam logic [5:0] SYM_PLUS  = 6'd62;
	localparam logic [5:0] SYM_SLASH = 6'd63;

	localparam logic [2:0] PAD_COUNT_MAX = 3'd7;
	localparam logic [3:0] MARKS_ONE_PAD = 4'h8;
	localparam logic [3:0] MARKS_TWO_PAD = 4'hc;

	typedef enum logic [1:0] {
		SK_SKIP,
		SK_PAD,
		SK_DATA
	} sym_kind_t;

	typedef struct packed {
		sym_kind_t   kind;
		logic [5:0]  value;
	} sym_t;

	// One queued work unit: up to three bytes plus end-of-message status.
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  cnt;
		logic        msg_end;
		logic        msg_err;
	} entry_t;

	function automatic sym_t map_char(input logic [7:0] c);
		sym_t s;
		logic [7:0] t;
		s.kind  = SK_DATA;
		s.value = '0;
		t       = '0;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			t = c - CHAR_UPPER_A;
			s.value = t[5:0];
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			t = c - 8'd71;
			s.value = t[5:0];
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			t = c + 8'd4;
			s.value = t[5:0];
		end else if (c == CHAR_PLUS) begin
			s.value = SYM_PLUS;
		end else if (c == CHAR_SLASH) begin
			s.value = SYM_SLASH;
		end else if (c == CHAR_PAD) begin
			s.kind = SK_PAD;
		end else begin
			s.kind = SK_SKIP;
		end
		return s;
	endfunction

endpackage

@@ rtl/core/b64d_front.sv @@
module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_code,
	input  logic                msg_last,
	input  logic                full,
	output logic                push,
	output b64d_pkg::entry_t    entry
);

	logic [5:0] store_q [3];
	logic [3:0] pad_marks_q;
	logic [1:0] count_q;
	logic [2:0] pad_count_q;
	logic       error_seen_q;

	b64d_pkg::sym_t ch;
	logic       acc;
	logic       is_sym;
	logic       is_pad;
	logic [5:0] sym_val;
	logic [3:0] marks_new;
	logic [2:0] pads_new;
	logic       complete;
	logic       ok;
	logic [1:0] cnt_raw;
	logic       err_new;

	assign in_ready = !full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		ch        = b64d_pkg::map_char(char_code);
		is_sym    = ch.kind != b64d_pkg::SK_SKIP;
		is_pad    = ch.kind == b64d_pkg::SK_PAD;
		sym_val   = is_pad ? 6'd0 : ch.value;
		marks_new = pad_marks_q | (is_pad ? (4'b0001 << count_q) : 4'b0000);
		pads_new  = (is_pad && pad_count_q != b64d_pkg::PAD_COUNT_MAX) ?
			pad_count_q + 3'd1 : pad_count_q;
		complete  = is_sym && count_q == 2'd3;
		case (pads_new)
			3'd0: begin
				ok      = 1'b1;
				cnt_raw = 2'd3;
			end
			3'd1: begin
				ok      = marks_new == b64d_pkg::MARKS_ONE_PAD && store_q[2][1:0] == 2'd0;
				cnt_raw = 2'd2;
			end
			3'd2: begin
				ok      = marks_new == b64d_pkg::MARKS_TWO_PAD && store_q[1][3:0] == 4'd0;
				cnt_raw = 2'd1;
			end
			default: begin
				ok      = 1'b0;
				cnt_raw = 2'd0;
			end
		endcase
		err_new       = error_seen_q || (complete && !ok);
		entry.bytes   = {store_q[0], store_q[1], store_q[2], sym_val};
		entry.cnt     = (complete && ok && !error_seen_q) ? cnt_raw : 2'd0;
		entry.msg_end = msg_last;
		// a group still open at the message end is malformed
		entry.msg_err = err_new || !complete;
		push          = acc && (entry.cnt != 2'd0 || msg_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q      <= '{default: '0};
			pad_marks_q  <= '0;
			count_q      <= '0;
			pad_count_q  <= '0;
			error_seen_q <= 1'b0;
		end else if (acc) begin
			if (msg_last || complete) begin
				store_q      <= '{default: '0};
				pad_marks_q  <= '0;
				count_q      <= '0;
				pad_count_q  <= '0;
				error_seen_q <= msg_last ? 1'b0 : err_new;
			end else begin
				if (is_sym) begin
					store_q[count_q] <= sym_val;
					pad_marks_q      <= marks_new;
					pad_count_q      <= pads_new;
					count_q          <= count_q + 2'd1;
				end
			end
		end
	end

endmodule

@@ rtl/core/b64d_fifo.sv @@
`include "base64_stream_decoder_macros.svh"

module b64d_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64d_pkg::entry_t din,
	input  logic             pop,
	output b64d_pkg::entry_t dout,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	b64d_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_FULL;
	assign empty = count_q == '0;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	`B64D_ASSERT_NOW(a_no_overflow, push, !full, "queue written while full")
	`B64D_ASSERT_NOW(a_no_underflow, pop, !empty, "queue read while empty")
	`B64D_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_FULL, "queue count out of range")
	`B64D_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after write")

endmodule

@@ rtl/core/b64d_back.sv @@
module b64d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64d_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,
	output logic             m_tlast,
	output logic [1:0]       m_tuser
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       end_q;
	logic       err_q;
	logic       bvalid_q;

	logic [1:0] last_idx;
	logic       last_of;
	logic       load;
	logic [7:0] sel_byte;

	always_comb begin
		last_idx = (head.cnt == 2'd0) ? 2'd0 : head.cnt - 2'd1;
		last_of  = idx_q == last_idx;
		load     = !valid_q || m_tready;
		pop      = load && !empty && last_of;
		case (idx_q)
			2'd0:    sel_byte = head.bytes[23:16];
			2'd1:    sel_byte = head.bytes[15:8];
			default: sel_byte = head.bytes[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			idx_q      <= '0;
			byte_q     <= '0;
			run_last_q <= 1'b0;
			end_q      <= 1'b0;
			err_q      <= 1'b0;
			bvalid_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				bvalid_q   <= head.cnt != 2'd0;
				byte_q     <= (head.cnt != 2'd0) ? sel_byte : 8'd0;
				run_last_q <= last_of;
				end_q      <= last_of && head.msg_end;
				err_q      <= last_of && head.msg_end && head.msg_err;
				idx_q      <= last_of ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, run_last_q, byte_q};
	assign m_tlast  = end_q;
	assign m_tuser  = {err_q, bvalid_q};

endmodule

@@ rtl/core/base64_stream_decoder.sv @@
// Base64 stream decoder: one character word in per cycle while s_tready is high,
// decoded bytes out. An entry is registered in the queue, then in the output stage.
// Throughput: 1 input word per cycle while s_tready is high; the output side emits
// 1 result word per cycle while m_tready is high, up to 3 per input word, buffered
// by a FIFO_DEPTH-entry queue; s_tready drops only while that queue is full.
// Reset: arst_n low clears group state, sticky error, queue and output valid.
module base64_stream_decoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic        s_tlast,  // message_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] data_byte, [8] run_last, [15:9] zero
	output logic        m_tlast,  // message_end
	output logic [1:0]  m_tuser   // [0] byte_valid, [1] message_error
);

	b64d_pkg::entry_t push_entry;
	b64d_pkg::entry_t head_entry;
	logic push;
	logic pop;
	logic full;
	logic empty;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.char_code (s_tdata),
		.msg_last  (s_tlast),
		.full      (full),
		.push      (push),
		.entry     (push_entry)
	);

	b64d_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_entry),
		.pop    (pop),
		.dout   (head_entry),
		.full   (full),
		.empty  (empty)
	);

	b64d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head_entry),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
